### rtl/bchc_pkg.sv
// Package for the button click / hold classifier.
// Holds register map, event codes and counter limits; no dependencies.
package bchc_pkg;

    // Counter saturation limit for press and release counts
    localparam logic [15:0] TICK_LIMIT = 16'd60000;

    // Register reset values
    localparam logic [15:0] HOLD_TICKS_RST      = 16'd1000;
    localparam logic [9:0]  MIN_PRESS_TICKS_RST = 10'd3;
    localparam logic [15:0] GAP_TICKS_RST       = 16'd30;

    // Register word indexes (byte address = 4 * index)
    localparam int unsigned REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_TICKS      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_PRESS_TICKS = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAP_TICKS       = 2'd2;

    // Event codes on the result word
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_HOLD   = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_SINGLE = 2'd3
    } event_kind_t;

    // Click tally value that resolves at once as a double click
    localparam logic [1:0] TALLY_DOUBLE = 2'd2;
    localparam logic [1:0] TALLY_SINGLE = 2'd1;

endpackage

### rtl/button_click_hold_classifier_top.sv
// Button click / hold classifier, top level.
// Depends on bchc_pkg (event codes, register map, counter limit).
//
// Usage:
//   Input channel (s_*): one word per sampling tick, s_tdata[0] is the pin
//   level (0 pressed, 1 released). Result channel (m_*): exactly one word per
//   input word, carrying the event decided on that tick and the pending-click
//   flag. Configuration goes through the APB port (hold_ticks at 0x0,
//   min_press_ticks at 0x4, gap_ticks at 0x8); write it only while idle.
//   The result is registered and appears in the cycle after acceptance.
//   Throughput: one tick per cycle while the receiver takes results. The
//   press/release counters and the click tally update from the accepted
//   word, and the result register sits behind them, so a new tick is taken
//   while the previous result is being taken downstream.
//   When the receiver stalls, the result register holds its word and
//   s_tready drops until it is taken; no word is lost.
//   Reset (aresetn low, synchronous) clears the counters, the tally and the
//   result valid flag, and loads the register defaults
//   (1000, 3, 30).
module button_click_hold_classifier_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] pin_level, [7:1] zero
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [1:0] event_kind, [2] clicks_pending, [7:3] zero
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [15:0] hold_ticks_reg;
    logic [9:0]  min_press_ticks_reg;
    logic [15:0] gap_ticks_reg;

    // Classifier state
    logic [15:0] press_ticks_reg,   press_ticks_next;
    logic [15:0] release_ticks_reg, release_ticks_next;
    logic [1:0]  click_tally_reg,   click_tally_next;

    // Result register
    logic                 out_valid_reg;
    bchc_pkg::event_kind_t event_reg, event_next;
    logic                 pending_reg;

    logic                 in_accept;
    logic                 cfg_write;
    logic [1:0]           reg_idx;
    logic                 pressed;
    logic [15:0]          press_inc;
    logic [1:0]           tally_rel;
    logic [15:0]          release_inc;

    // APB access
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_ticks_reg      <= bchc_pkg::HOLD_TICKS_RST;
            min_press_ticks_reg <= bchc_pkg::MIN_PRESS_TICKS_RST;
            gap_ticks_reg       <= bchc_pkg::GAP_TICKS_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                bchc_pkg::REG_HOLD_TICKS:      hold_ticks_reg      <= pwdata[15:0];
                bchc_pkg::REG_MIN_PRESS_TICKS: min_press_ticks_reg <= pwdata[9:0];
                bchc_pkg::REG_GAP_TICKS:       gap_ticks_reg       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bchc_pkg::REG_HOLD_TICKS:      prdata = {16'd0, hold_ticks_reg};
            bchc_pkg::REG_MIN_PRESS_TICKS: prdata = {22'd0, min_press_ticks_reg};
            bchc_pkg::REG_GAP_TICKS:       prdata = {16'd0, gap_ticks_reg};
            default:                       prdata = 32'd0;
        endcase
    end

    // Handshake: take a word whenever the result slot is free or being drained
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign pressed   = !s_tdata[0];

    // Saturating increments
    assign press_inc   = (press_ticks_reg < bchc_pkg::TICK_LIMIT) ?
                         press_ticks_reg + 16'd1 : press_ticks_reg;
    assign release_inc = (release_ticks_reg < bchc_pkg::TICK_LIMIT) ?
                         release_ticks_reg + 16'd1 : release_ticks_reg;

    // Tally after a release edge possibly adds one click
    always_comb begin
        tally_rel = click_tally_reg;
        if (press_ticks_reg != 16'd0 &&
            press_ticks_reg > {6'd0, min_press_ticks_reg} &&
            press_ticks_reg < hold_ticks_reg) begin
            tally_rel = click_tally_reg + 2'd1;
        end
    end

    // Per-tick classification
    always_comb begin
        press_ticks_next   = press_ticks_reg;
        release_ticks_next = release_ticks_reg;
        click_tally_next   = click_tally_reg;
        event_next         = bchc_pkg::EV_NONE;
        if (pressed) begin
            release_ticks_next = 16'd0;
            press_ticks_next   = press_inc;
            if (press_inc == hold_ticks_reg) begin
                event_next       = bchc_pkg::EV_HOLD;
                click_tally_next = 2'd0;
            end
        end else begin
            press_ticks_next = 16'd0;
            click_tally_next = tally_rel;
            if (tally_rel != 2'd0) begin
                release_ticks_next = release_inc;
                if (tally_rel == bchc_pkg::TALLY_DOUBLE) begin
                    event_next         = bchc_pkg::EV_DOUBLE;
                    click_tally_next   = 2'd0;
                    release_ticks_next = 16'd0;
                end else if (release_inc > gap_ticks_reg) begin
                    if (tally_rel == bchc_pkg::TALLY_SINGLE) begin
                        event_next = bchc_pkg::EV_SINGLE;
                    end
                    click_tally_next   = 2'd0;
                    release_ticks_next = 16'd0;
                end
            end else begin
                release_ticks_next = 16'd0;
            end
        end
    end

    // State and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_ticks_reg   <= 16'd0;
            release_ticks_reg <= 16'd0;
            click_tally_reg   <= 2'd0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (in_accept) begin
                press_ticks_reg   <= press_ticks_next;
                release_ticks_reg <= release_ticks_next;
                click_tally_reg   <= click_tally_next;
                out_valid_reg     <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            event_reg   <= event_next;
            pending_reg <= click_tally_next[0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, pending_reg, event_reg};

    // Checks
    a_release_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        click_tally_reg == 2'd0 |-> release_ticks_reg == 16'd0)
        else $error("release counter running with no click pending");

    a_press_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        press_ticks_reg <= bchc_pkg::TICK_LIMIT)
        else $error("press counter beyond saturation limit");

    a_event_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (event_reg == bchc_pkg::EV_HOLD || event_reg == bchc_pkg::EV_DOUBLE ||
                     event_reg == bchc_pkg::EV_SINGLE) |-> !pending_reg)
        else $error("event reported while clicks still pending");

    a_one_per_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> m_tvalid)
        else $error("accepted tick produced no result");

endmodule
